@@ hw/rtl/rsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg: shared types, constants and helpers of the radix string converter
// Character codes, widths derived from the value width, payload structs,
// the sequencer state type and the digit/character mapping functions.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // Width of the accumulated magnitude
  localparam int VALUE_BITS = 31;
  localparam logic [VALUE_BITS-1:0] MAG_MAX = '1;

  localparam int RADIX_W = 6;
  localparam int DIG_W   = 6;
  // Index into the digit store, and a count that can also hold VALUE_BITS
  localparam int IDX_W   = $clog2(VALUE_BITS);
  localparam int NUM_W   = $clog2(VALUE_BITS + 1);
  localparam int STEP_W  = $clog2(VALUE_BITS);

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [DIG_W-1:0] DEC_DIGITS = 6'd10;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  // Configuration register indexes
  localparam logic REG_SOURCE_RADIX = 1'b0;
  localparam logic REG_TARGET_RADIX = 1'b1;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       overflow;
  } out_item_t;

  // Divider request from the sequencer
  typedef struct packed {
    logic                  load;
    logic [VALUE_BITS-1:0] dividend;
    logic [RADIX_W-1:0]    radix;
  } div_req_t;

  // Divider result back to the sequencer
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIG_W-1:0]      remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } seq_state_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [DIG_W-1:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_0 && c <= CH_9) d = c - CH_0;
    else if (c >= CH_A && c <= CH_Z) d = c - CH_A + 8'(DEC_DIGITS);
    return d[DIG_W-1:0];
  endfunction

  function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
    logic [7:0] c;
    if (d < DEC_DIGITS) c = CH_0 + 8'(d);
    else c = CH_A + 8'(d) - 8'(DEC_DIGITS);
    return c;
  endfunction

endpackage

@@ hw/rtl/radix_string_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_string_converter: signed numeral re-writer between two radices
// Accumulates an input numeral one character per transfer and, on the last
// character, streams the value out in the target radix.
// ----------------------------------------------------------------------------
// A character is taken on start whenever busy is low; a character not
// marked last leaves busy low. After the last character busy stays high
// while the value is converted: each output digit costs one pass of the
// bit-serial divider. The result characters then come out one by one, each
// read from the digit store and then put on the output, and each marked by
// out_valid for a single cycle; the receiver must take them as they come,
// since there is no back-pressure. A zero value gives a single '0' through
// the check state and the output register, with no divider pass.
// ----------------------------------------------------------------------------
module radix_string_converter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rsc_pkg::in_item_t            in_item,
  output logic                         out_valid,
  output rsc_pkg::out_item_t           out_item,
  input  logic                         cfg_we,
  input  logic                         cfg_idx,
  input  logic [rsc_pkg::RADIX_W-1:0]  cfg_data
);
  import rsc_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [RADIX_W-1:0] src_radix_r, tgt_radix_r;

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              take;
  logic              acc_clear;
  logic [VALUE_BITS-1:0] mag;
  logic              neg;
  logic              sat;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              mem_we;
  logic [DIG_W-1:0]  digit_mem [VALUE_BITS];
  logic [DIG_W-1:0]  rd_data_r;

  assign busy = (state_r != ST_IDLE);
  assign take = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_radix_r <= 6'd10;
      tgt_radix_r <= RADIX_MIN;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SOURCE_RADIX: src_radix_r <= cfg_data;
        REG_TARGET_RADIX: tgt_radix_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rsc_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .clear   (acc_clear),
    .char_in (in_item.in_char),
    .radix   (clamp_radix(src_radix_r)),
    .mag     (mag),
    .neg     (neg),
    .sat     (sat)
  );

  rsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Digit store: written low digit first, read back from the top
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[num_r[IDX_W-1:0]] <= div_rsp.remainder;
    end
    rd_data_r <= digit_mem[idx_r];
  end

  always_comb begin
    state_nxt        = state_r;
    num_nxt          = num_r;
    idx_nxt          = idx_r;
    out_valid_nxt    = 1'b0;
    out_item_nxt     = out_item_r;
    acc_clear        = 1'b0;
    mem_we           = 1'b0;
    div_req.load     = 1'b0;
    div_req.dividend = mag;
    div_req.radix    = clamp_radix(tgt_radix_r);

    unique case (state_r)
      ST_IDLE: begin
        if (take && in_item.in_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (mag == '0) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.out_char = CH_0;
          out_item_nxt.out_last = 1'b1;
          out_item_nxt.overflow = sat;
          acc_clear             = 1'b1;
          state_nxt             = ST_IDLE;
        end else begin
          div_req.load = 1'b1;
          num_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          mem_we  = 1'b1;
          num_nxt = num_r + 1'b1;
          if (div_rsp.quotient == '0 || num_r == NUM_W'(VALUE_BITS - 1)) begin
            state_nxt = ST_SIGN;
          end else begin
            // next digit from the quotient
            div_req.load     = 1'b1;
            div_req.dividend = div_rsp.quotient;
          end
        end
      end
      ST_SIGN: begin
        idx_nxt = IDX_W'(num_r - 1'b1);
        if (neg) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.out_char = CH_MINUS;
          out_item_nxt.out_last = 1'b0;
          out_item_nxt.overflow = sat;
        end
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_nxt         = 1'b1;
        out_item_nxt.out_char = digit_char(rd_data_r);
        out_item_nxt.out_last = (idx_r == '0);
        out_item_nxt.overflow = sat;
        if (idx_r == '0) begin
          acc_clear = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      num_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      num_r       <= num_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hw/rtl/rsc_acc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_acc: numeral accumulator
// Folds one character per transfer into the magnitude as m * radix + digit,
// tracks the sign and the first-character flag, and saturates the magnitude.
// ----------------------------------------------------------------------------
module rsc_acc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic                           clear,
  input  logic [7:0]                     char_in,
  input  logic [rsc_pkg::RADIX_W-1:0]    radix,
  output logic [rsc_pkg::VALUE_BITS-1:0] mag,
  output logic                           neg,
  output logic                           sat
);
  import rsc_pkg::*;

  localparam int SUM_W = VALUE_BITS + RADIX_W + 1;

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  first_r, first_nxt;
  logic                  sat_r, sat_nxt;
  logic [SUM_W-1:0]      sum;

  assign sum = SUM_W'(mag_r) * SUM_W'(radix) + SUM_W'(digit_value(char_in));

  always_comb begin
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    first_nxt = first_r;
    sat_nxt   = sat_r;
    if (clear) begin
      mag_nxt   = '0;
      neg_nxt   = 1'b0;
      first_nxt = 1'b1;
      sat_nxt   = 1'b0;
    end else if (take) begin
      first_nxt = 1'b0;
      if (first_r && char_in == CH_MINUS) begin
        neg_nxt = 1'b1;
      end else if (sum[SUM_W-1:VALUE_BITS] != '0) begin
        // clamp at full scale
        mag_nxt = MAG_MAX;
        sat_nxt = 1'b1;
      end else begin
        mag_nxt = sum[VALUE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r   <= '0;
      neg_r   <= 1'b0;
      first_r <= 1'b1;
      sat_r   <= 1'b0;
    end else begin
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      first_r <= first_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign mag = mag_r;
  assign neg = neg_r;
  assign sat = sat_r;

endmodule

@@ hw/rtl/rsc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_div: bit-serial restoring divider
// Divides the magnitude by the target radix, one quotient bit per cycle;
// done pulses with quotient and remainder.
// ----------------------------------------------------------------------------
module rsc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rsc_pkg::div_req_t   req,
  output rsc_pkg::div_rsp_t   rsp
);
  import rsc_pkg::*;

  logic [VALUE_BITS-1:0] dq_r, dq_nxt;
  logic [DIG_W-1:0]      rem_r, rem_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [DIG_W:0]        trial;
  logic [DIG_W:0]        diff;
  logic                  ge;

  assign trial = {rem_r, dq_r[VALUE_BITS-1]};
  assign ge    = trial >= (DIG_W+1)'(radix_r);
  assign diff  = trial - (DIG_W+1)'(radix_r);

  always_comb begin
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    step_nxt  = step_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    if (req.load) begin
      dq_nxt    = req.dividend;
      rem_nxt   = '0;
      radix_nxt = req.radix;
      step_nxt  = '0;
      run_nxt   = 1'b1;
    end else if (run_r) begin
      // shift in one dividend bit, subtract when it fits
      dq_nxt  = {dq_r[VALUE_BITS-2:0], ge};
      rem_nxt = ge ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(VALUE_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dq_r;
  assign rsp.remainder = rem_r;

endmodule

@@ tb/sv/radix_string_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_string_converter_tb: self-checking bench for the radix converter
// Feeds numerals one character per transfer under a range of source and
// target radix settings, predicts the converted characters in the bench and
// checks every output strobe against the oldest predicted character.
// ----------------------------------------------------------------------------
module radix_string_converter_tb;
  import rsc_pkg::*;

  localparam longint unsigned MAG_CAP = (64'd1 << VALUE_BITS) - 64'd1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic                 cfg_idx = REG_SOURCE_RADIX;
  logic [RADIX_W-1:0]   cfg_data = '0;

  radix_string_converter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the converter state and registers
  logic [RADIX_W-1:0] src_radix = 6'd10;
  logic [RADIX_W-1:0] tgt_radix = 6'd2;
  longint unsigned    acc_mag = 0;
  bit                 neg_numeral = 1'b0;
  bit                 sat_numeral = 1'b0;
  bit                 at_first = 1'b1;

  in_item_t  pending_chars[$];
  out_item_t expected_chars[$];

  int  queued_count = 0;
  int  chars_in = 0;
  int  chars_out = 0;
  int  numerals_done = 0;
  int  negative_numerals = 0;
  int  saturated_numerals = 0;
  int  fail_count = 0;
  int  gap_left = 0;
  bit  no_idle = 1'b0;

  function automatic longint unsigned eff_radix(input logic [RADIX_W-1:0] r);
    if (r < 6'd2) return 2;
    if (r > 6'd36) return 36;
    return longint'(r);
  endfunction

  function automatic longint unsigned char_weight(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return longint'(c - CH_0);
    if (c >= CH_A && c <= CH_Z) return longint'(c - CH_A) + 10;
    return 0;
  endfunction

  function automatic logic [7:0] weight_char(input logic [DIG_W-1:0] d);
    if (d < 6'd10) return CH_0 + 8'(d);
    return CH_A + 8'(d) - 8'd10;
  endfunction

  // Fold one character into the numeral; on the last one queue its rewrite
  task automatic convert_char(input in_item_t it);
    longint unsigned r, d, v;
    int n, total, k;
    logic [DIG_W-1:0] digs [VALUE_BITS];
    out_item_t res;
    if (at_first && it.in_char == CH_MINUS) begin
      neg_numeral = 1'b1;
    end else begin
      r = eff_radix(src_radix);
      d = char_weight(it.in_char);
      if (acc_mag > (MAG_CAP - d) / r) begin
        acc_mag = MAG_CAP;
        sat_numeral = 1'b1;
      end else begin
        acc_mag = acc_mag * r + d;
      end
    end
    at_first = 1'b0;
    if (!it.in_last) return;

    numerals_done++;
    if (neg_numeral) negative_numerals++;
    if (sat_numeral) saturated_numerals++;
    res.overflow = sat_numeral;
    if (acc_mag == 0) begin
      res.out_char = CH_0;
      res.out_last = 1'b1;
      expected_chars.push_back(res);
    end else begin
      r = eff_radix(tgt_radix);
      v = acc_mag;
      n = 0;
      while (v > 0 && n < VALUE_BITS) begin
        digs[n] = DIG_W'(v % r);
        v = v / r;
        n++;
      end
      total = n + (neg_numeral ? 1 : 0);
      k = 0;
      if (neg_numeral) begin
        res.out_char = CH_MINUS;
        res.out_last = (total == 1);
        expected_chars.push_back(res);
        k = 1;
      end
      for (int i = n - 1; i >= 0; i--) begin
        res.out_char = weight_char(digs[i]);
        res.out_last = (k == total - 1);
        expected_chars.push_back(res);
        k++;
      end
    end
    acc_mag = 0;
    neg_numeral = 1'b0;
    sat_numeral = 1'b0;
    at_first = 1'b1;
  endtask

  task automatic push_char(input logic [7:0] c, input bit last);
    in_item_t it;
    it.in_char = c;
    it.in_last = last;
    pending_chars.push_back(it);
    queued_count++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // Mostly well-formed numerals, some long enough to saturate, some broken
  task automatic queue_random_numeral();
    int kind, len, rmax;
    kind = $urandom_range(0, 9);
    rmax = int'(eff_radix(src_radix)) - 1;
    if (kind <= 6) begin
      if ($urandom_range(0, 1) == 1) push_char(CH_MINUS, 1'b0);
      if (kind == 6) len = $urandom_range(20, 34);
      else if ($urandom_range(0, 5) == 0) len = $urandom_range(7, 12);
      else len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        push_char(weight_char(DIG_W'($urandom_range(0, rmax))), i == len - 1);
    end else if (kind == 7) begin
      push_char(CH_MINUS, 1'b0);
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 2) == 0) push_char(CH_MINUS, i == len - 1);
        else push_char(weight_char(DIG_W'($urandom_range(0, 35))), i == len - 1);
      end
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) push_char(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [RADIX_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == REG_SOURCE_RADIX) src_radix = val;
    else tgt_radix = val;
  endtask

  // Hold until the converter has drained everything in flight
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_chars.size() != 0 || start || expected_chars.size() != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    bit take_next;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      take_next = 1'b0;
      if (start && !busy) begin
        convert_char(in_item);
        chars_in++;
        take_next = 1'b1;
      end else if (!start) begin
        take_next = 1'b1;
      end
      if (take_next) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_chars.size() != 0 && !no_idle && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 4);
          start <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          in_item <= pending_chars.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid) begin
      chars_out++;
      if (expected_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected output: char %h last %b ovf %b",
                   out_item.out_char, out_item.out_last, out_item.overflow);
      end else begin
        want = expected_chars.pop_front();
        if (out_item.out_char !== want.out_char || out_item.out_last !== want.out_last ||
            out_item.overflow !== want.overflow) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: got char %h last %b ovf %b, want char %h last %b ovf %b",
                     out_item.out_char, out_item.out_last, out_item.overflow,
                     want.out_char, want.out_last, want.overflow);
        end
      end
    end
  end

  initial begin : stimulus
    int goal;
    int src_tab [7] = '{16, 0, 63, 36, 2, 37, 8};
    int tgt_tab [7] = '{10, 36, 1, 2, 16, 63, 3};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset radices: zero, lone minus, minus zero, minus inside, oversized digit,
    // non-digit characters, and a negative value that saturates
    queue_text("0");
    queue_text("-");
    queue_text("-0");
    queue_text("7-3");
    queue_text("Z");
    push_char(8'hFF, 1'b0);
    push_char(8'h00, 1'b1);
    queue_text("-9999999999");
    wait_quiet();

    for (int p = 0; p < 9; p++) begin
      if (p < 7) begin
        write_reg(REG_SOURCE_RADIX, RADIX_W'(src_tab[p]));
        write_reg(REG_TARGET_RADIX, RADIX_W'(tgt_tab[p]));
      end else begin
        write_reg(REG_SOURCE_RADIX, RADIX_W'($urandom_range(0, 63)));
        write_reg(REG_TARGET_RADIX, RADIX_W'($urandom_range(0, 63)));
      end
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      if (p == 8) no_idle = 1'b1;
      if (p == 0) begin
        // largest magnitude, then one past it
        queue_text("7FFFFFFF");
        queue_text("80000000");
      end
      goal = queued_count + 29;
      while (queued_count < goal) queue_random_numeral();
      wait_quiet();
    end

    repeat (64) @(posedge clk);
    fail_count += expected_chars.size();
    $display("%0d characters in, %0d out, over %0d numerals", chars_in, chars_out,
             numerals_done);
    $display("%0d numerals negative, %0d saturated, 9 radix settings after reset",
             negative_numerals, saturated_numerals);
    if (fail_count == 0) begin
      $display("radix_string_converter_tb: clean");
    end else begin
      $display("radix_string_converter_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("radix_string_converter_tb: errors");
    $finish;
  end

endmodule
